// ===== hdl/kps_pkg.sv =====
// ----------------------------------------------------------------------------
// kps_pkg: shared definitions for the keypad scanner
// Widths, queue depth, key code table and the structs passed between the
// scanner's sub-blocks.
// ----------------------------------------------------------------------------
package kps_pkg;

  // Matrix and key numbering
  localparam int NUM_KEYS  = 16;
  localparam int KEY_NUM_W = $clog2(NUM_KEYS);
  // key index: 0 = no key, otherwise key number + 1
  localparam int KEY_IDX_W = $clog2(NUM_KEYS + 1);
  localparam int CODE_W    = 8;
  localparam int TICKS_W   = 8;

  // Key queue
  localparam int QUEUE_DEPTH = 16;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int LEVEL_W     = $clog2(QUEUE_DEPTH + 1);

  localparam logic [PTR_W-1:0]   LAST_SLOT   = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [LEVEL_W-1:0] LEVEL_FULL  = LEVEL_W'(QUEUE_DEPTH);
  localparam logic [TICKS_W-1:0] TICKS_RESET = TICKS_W'(3);

  localparam logic ACT_SCAN = 1'b0;
  localparam logic ACT_READ = 1'b1;

  // Result of priority-encoding one matrix sample
  typedef struct packed {
    logic [KEY_IDX_W-1:0] idx;
    logic [CODE_W-1:0]    code;
  } key_hit_t;

  // Queue controls
  typedef struct packed {
    logic              push;
    logic              pop;
    logic [CODE_W-1:0] wdata;
  } fifo_ctrl_t;

  // Queue status
  typedef struct packed {
    logic [CODE_W-1:0]  rd_data;
    logic [LEVEL_W-1:0] level;
    logic               full;
    logic               empty;
  } fifo_stat_t;

  // ASCII code of each key, row-major
  function automatic logic [CODE_W-1:0] key_code_of(input logic [KEY_NUM_W-1:0] k);
    logic [CODE_W-1:0] c;
    unique case (k)
      4'd0:    c = 8'h31; // '1'
      4'd1:    c = 8'h32; // '2'
      4'd2:    c = 8'h33; // '3'
      4'd3:    c = 8'h61; // 'a'
      4'd4:    c = 8'h34; // '4'
      4'd5:    c = 8'h35; // '5'
      4'd6:    c = 8'h36; // '6'
      4'd7:    c = 8'h62; // 'b'
      4'd8:    c = 8'h37; // '7'
      4'd9:    c = 8'h38; // '8'
      4'd10:   c = 8'h39; // '9'
      4'd11:   c = 8'h63; // 'c'
      4'd12:   c = 8'h73; // 's'
      4'd13:   c = 8'h30; // '0'
      4'd14:   c = 8'h70; // 'p'
      4'd15:   c = 8'h64; // 'd'
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== hdl/kps_encoder.sv =====
// ----------------------------------------------------------------------------
// kps_encoder: matrix priority encoder
// Finds the first pressed key in row-major order and maps it to its code.
// ----------------------------------------------------------------------------
module kps_encoder (
  input  logic [kps_pkg::NUM_KEYS-1:0] key_matrix,
  output kps_pkg::key_hit_t            hit
);
  import kps_pkg::*;

  logic [KEY_IDX_W-1:0] idx;
  logic [KEY_IDX_W-1:0] idx_less;

  // lowest set bit wins; scan from the top so the lowest overrides
  always_comb begin
    idx = '0;
    for (int b = NUM_KEYS - 1; b >= 0; b--) begin
      if (key_matrix[b]) begin
        idx = KEY_IDX_W'(b + 1);
      end
    end
  end

  assign idx_less = idx - KEY_IDX_W'(1);
  assign hit.idx  = idx;
  assign hit.code = key_code_of(idx_less[KEY_NUM_W-1:0]);

endmodule

// ===== hdl/kps_debounce.sv =====
// ----------------------------------------------------------------------------
// kps_debounce: press detection with refractory countdown
// Tracks the last key seen and counts scan ticks after a release; flags a
// press that may be queued.
// ----------------------------------------------------------------------------
module kps_debounce (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           scan,
  input  logic [kps_pkg::KEY_IDX_W-1:0]  idx,
  input  logic [kps_pkg::TICKS_W-1:0]    refractory_ticks,
  output logic                           press
);
  import kps_pkg::*;

  logic [KEY_IDX_W-1:0] last_key_index;
  logic [KEY_IDX_W-1:0] last_key_index_next;
  logic [TICKS_W-1:0]   refractory_left;
  logic [TICKS_W-1:0]   refractory_left_next;
  logic [TICKS_W-1:0]   left_dec;
  logic                 changed;

  // countdown steps first, then release reloads it
  always_comb begin
    left_dec = (refractory_left != '0) ? refractory_left - TICKS_W'(1) : '0;
    changed  = (idx != last_key_index);
    last_key_index_next  = last_key_index;
    refractory_left_next = refractory_left;
    press = 1'b0;
    if (scan) begin
      refractory_left_next = left_dec;
      if (changed) begin
        last_key_index_next = idx;
        if (idx == '0) begin
          refractory_left_next = refractory_ticks;
        end else begin
          press = (left_dec == '0);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_key_index  <= '0;
      refractory_left <= '0;
    end else begin
      last_key_index  <= last_key_index_next;
      refractory_left <= refractory_left_next;
    end
  end

endmodule

// ===== hdl/kps_fifo.sv =====
// ----------------------------------------------------------------------------
// kps_fifo: key code queue
// Circular buffer of key codes with head, tail and fill count.
// ----------------------------------------------------------------------------
module kps_fifo (
  input  logic                clk,
  input  logic                rst,
  input  kps_pkg::fifo_ctrl_t ctrl,
  output kps_pkg::fifo_stat_t stat
);
  import kps_pkg::*;

  logic [CODE_W-1:0]  key_fifo [QUEUE_DEPTH];
  logic [PTR_W-1:0]   fifo_head;
  logic [PTR_W-1:0]   fifo_tail;
  logic [LEVEL_W-1:0] fifo_count;

  // storage: no reset, entries are read only after being written
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      key_fifo[fifo_tail] <= ctrl.wdata;
    end
  end

  // pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      fifo_head  <= '0;
      fifo_tail  <= '0;
      fifo_count <= '0;
    end else begin
      if (ctrl.push) begin
        fifo_tail <= (fifo_tail == LAST_SLOT) ? '0 : fifo_tail + PTR_W'(1);
      end
      if (ctrl.pop) begin
        fifo_head <= (fifo_head == LAST_SLOT) ? '0 : fifo_head + PTR_W'(1);
      end
      if (ctrl.push && !ctrl.pop) begin
        fifo_count <= fifo_count + LEVEL_W'(1);
      end else if (ctrl.pop && !ctrl.push) begin
        fifo_count <= fifo_count - LEVEL_W'(1);
      end
    end
  end

  assign stat.rd_data = key_fifo[fifo_head];
  assign stat.level   = fifo_count;
  assign stat.full    = (fifo_count == LEVEL_FULL);
  assign stat.empty   = (fifo_count == '0);

endmodule

// ===== hdl/matrix_keypad_scanner_unit.sv =====
// ----------------------------------------------------------------------------
// matrix_keypad_scanner_unit: 4x4 keypad scanner with debounce and key queue
// Scan ticks find and debounce key presses and queue their codes; reads pop
// one code. One result item per input item.
// ----------------------------------------------------------------------------
// Takes one item per clock cycle while results are taken: an input
// register feeds the encoder, debounce and queue logic, whose outcome
// lands in a result register. in_ready drops only while both registers
// are full and the result is not taken. The key queue holds QUEUE_DEPTH
// codes; the level reported is the one after the item. Write
// refractory_ticks only while no items are in flight.
module matrix_keypad_scanner_unit (
  input  logic                           clk,
  input  logic                           rst,
  // input item channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           action,
  input  logic [kps_pkg::NUM_KEYS-1:0]   key_matrix,
  // result item channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [kps_pkg::CODE_W-1:0]     key_code,
  output logic                           key_valid,
  output logic                           key_dropped,
  output logic [kps_pkg::LEVEL_W-1:0]    queue_level,
  // configuration
  input  logic                           cfg_wen,
  input  logic [kps_pkg::TICKS_W-1:0]    cfg_wdata
);
  import kps_pkg::*;

  logic                s1_valid;
  logic                s1_action;
  logic [NUM_KEYS-1:0] s1_matrix;
  logic                s1_advance;
  logic [TICKS_W-1:0]  refractory_ticks;
  key_hit_t            hit;
  logic                scan;
  logic                press;
  fifo_ctrl_t          fctrl;
  fifo_stat_t          fstat;
  logic                do_pop;
  logic                dropped;
  logic [LEVEL_W-1:0]  level_next;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      refractory_ticks <= TICKS_RESET;
    end else if (cfg_wen) begin
      refractory_ticks <= cfg_wdata;
    end
  end

  // handshake
  assign s1_advance = s1_valid && (!out_valid || out_ready);
  assign in_ready   = !s1_valid || s1_advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_action <= action;
      s1_matrix <= key_matrix;
    end
  end

  // processing
  kps_encoder u_encoder (
    .key_matrix (s1_matrix),
    .hit        (hit)
  );

  assign scan = s1_advance && (s1_action == ACT_SCAN);

  kps_debounce u_debounce (
    .clk              (clk),
    .rst              (rst),
    .scan             (scan),
    .idx              (hit.idx),
    .refractory_ticks (refractory_ticks),
    .press            (press)
  );

  assign do_pop      = s1_advance && (s1_action == ACT_READ) && !fstat.empty;
  assign dropped     = press && fstat.full;
  assign fctrl.push  = press && !fstat.full;
  assign fctrl.pop   = do_pop;
  assign fctrl.wdata = hit.code;

  kps_fifo u_fifo (
    .clk  (clk),
    .rst  (rst),
    .ctrl (fctrl),
    .stat (fstat)
  );

  // level after this item
  always_comb begin
    level_next = fstat.level;
    if (fctrl.push) begin
      level_next = fstat.level + LEVEL_W'(1);
    end else if (do_pop) begin
      level_next = fstat.level - LEVEL_W'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      key_code    <= do_pop ? fstat.rd_data : '0;
      key_valid   <= do_pop;
      key_dropped <= dropped;
      queue_level <= level_next;
    end
  end

`ifndef SYNTH
  // a result cannot both pop a key and drop one
  a_pop_xor_drop: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(key_valid && key_dropped))
    else $error("key_valid and key_dropped both set");

  // a drop only happens against a full queue
  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    (out_valid && key_dropped) |-> (queue_level == LEVEL_FULL))
    else $error("key dropped while queue not full");

  // a popped key leaves room and carries a real code
  a_pop_code: assert property (@(posedge clk) disable iff (rst)
    (out_valid && key_valid) |-> (key_code != '0 && queue_level != LEVEL_FULL))
    else $error("bad popped key");

  // fill count stays within the depth
  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    fstat.level <= LEVEL_FULL)
    else $error("queue level beyond depth");

  // a stalled result does not let the input stage advance
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !s1_advance)
    else $error("input stage advanced into a stalled result");
`endif

endmodule

// ===== dv/kps_checker.sv =====
// ----------------------------------------------------------------------------
// keypad_result_checker: result predictor and scoreboard for the keypad scanner
// Watches the input, result and register ports of the scanner. It keeps its
// own copy of the debounce state and the key queue, works out the result of
// every accepted item and compares each accepted result, field by field, with
// the oldest one outstanding.
// ----------------------------------------------------------------------------
module keypad_result_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic                          action,
  input  logic [kps_pkg::NUM_KEYS-1:0]  key_matrix,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [kps_pkg::CODE_W-1:0]    key_code,
  input  logic                          key_valid,
  input  logic                          key_dropped,
  input  logic [kps_pkg::LEVEL_W-1:0]   queue_level,
  input  logic                          cfg_wen,
  input  logic [kps_pkg::TICKS_W-1:0]   cfg_wdata,
  output int                            mismatch_total,
  output int                            outstanding
);
  import kps_pkg::*;

  typedef struct packed {
    logic [CODE_W-1:0]  code;
    logic               valid;
    logic               dropped;
    logic [LEVEL_W-1:0] level;
  } key_result_t;

  // ASCII legend, key 0 in the top byte
  localparam logic [8*NUM_KEYS-1:0] KEY_LEGEND = "123a456b789cs0pd";

  // Predicted scanner state
  logic [TICKS_W-1:0]   debounce_ticks;
  logic [TICKS_W-1:0]   debounce_left;
  logic [KEY_IDX_W-1:0] held_idx;
  logic [CODE_W-1:0]    code_store [QUEUE_DEPTH];
  logic [PTR_W-1:0]     rd_ptr;
  logic [PTR_W-1:0]     wr_ptr;
  logic [LEVEL_W-1:0]   stored;

  key_result_t expected_results[$];
  int          fail_tally = 0;

  initial begin
    mismatch_total = 0;
    outstanding    = 0;
  end

  task automatic flag_mismatch(input string msg);
    fail_tally++;
    if (fail_tally <= 10) begin
      $display("mismatch: %s", msg);
    end
  endtask

  // Apply one item to the predicted state and queue the result it gives
  task automatic predict_key_result(input logic act, input logic [NUM_KEYS-1:0] m);
    key_result_t          r;
    logic [KEY_IDX_W-1:0] idx;
    r = '0;
    if (act == ACT_READ) begin
      if (stored != 0) begin
        r.code  = code_store[rd_ptr];
        r.valid = 1'b1;
        rd_ptr  = rd_ptr + 1'b1;
        stored  = stored - 1'b1;
      end
    end else begin
      // lowest set bit wins
      idx = '0;
      for (int b = NUM_KEYS - 1; b >= 0; b--) begin
        if (m[b]) idx = KEY_IDX_W'(b + 1);
      end
      if (debounce_left != 0) debounce_left = debounce_left - 1'b1;
      if (idx != held_idx) begin
        held_idx = idx;
        if (idx == 0) begin
          debounce_left = debounce_ticks;
        end else if (debounce_left == 0) begin
          if (stored == LEVEL_FULL) begin
            r.dropped = 1'b1;
          end else begin
            code_store[wr_ptr] = KEY_LEGEND[8 * (NUM_KEYS - int'(idx)) +: 8];
            wr_ptr = wr_ptr + 1'b1;
            stored = stored + 1'b1;
          end
        end
      end
    end
    r.level = stored;
    expected_results.push_back(r);
  endtask

  // Results are checked before new items are predicted: a result never
  // belongs to an item accepted at the same edge.
  always @(posedge clk) begin
    key_result_t want;
    if (rst) begin
      debounce_ticks = TICKS_RESET;
      debounce_left  = '0;
      held_idx       = '0;
      rd_ptr         = '0;
      wr_ptr         = '0;
      stored         = '0;
      expected_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          flag_mismatch($sformatf("unexpected result code=%h valid=%b dropped=%b level=%0d",
                                  key_code, key_valid, key_dropped, queue_level));
        end else begin
          want = expected_results.pop_front();
          if (key_code !== want.code)
            flag_mismatch($sformatf("key_code exp %h got %h", want.code, key_code));
          if (key_valid !== want.valid)
            flag_mismatch($sformatf("key_valid exp %b got %b", want.valid, key_valid));
          if (key_dropped !== want.dropped)
            flag_mismatch($sformatf("key_dropped exp %b got %b", want.dropped, key_dropped));
          if (queue_level !== want.level)
            flag_mismatch($sformatf("queue_level exp %0d got %0d", want.level, queue_level));
        end
      end
      if (in_valid && in_ready) predict_key_result(action, key_matrix);
      if (cfg_wen) debounce_ticks = cfg_wdata;
    end
    mismatch_total <= fail_tally;
    outstanding    <= expected_results.size();
  end

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the keypad scanner
// A short directed run covers empty reads, holds, key switches, presses
// inside the debounce window, priority and a full queue; random keypress
// sequences with reads then follow under several debounce settings and
// handshake idling patterns. Checking is done by keypad_result_checker.
// ----------------------------------------------------------------------------
module testbench;
  import kps_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE      = 4;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                action = ACT_SCAN;
  logic [NUM_KEYS-1:0] key_matrix = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [CODE_W-1:0]   key_code;
  logic                key_valid;
  logic                key_dropped;
  logic [LEVEL_W-1:0]  queue_level;
  logic                cfg_wen = 1'b0;
  logic [TICKS_W-1:0]  cfg_wdata = '0;

  int mismatch_total;
  int outstanding;
  int tx_idle_pct = 25;
  int rx_idle_pct = 45;
  int cycle_count = 0;

  logic [NUM_KEYS-1:0] held_matrix = '0;

  always #6 clk = ~clk;

  matrix_keypad_scanner_unit uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .action      (action),
    .key_matrix  (key_matrix),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .key_code    (key_code),
    .key_valid   (key_valid),
    .key_dropped (key_dropped),
    .queue_level (queue_level),
    .cfg_wen     (cfg_wen),
    .cfg_wdata   (cfg_wdata)
  );

  keypad_result_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .action         (action),
    .key_matrix     (key_matrix),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .key_code       (key_code),
    .key_valid      (key_valid),
    .key_dropped    (key_dropped),
    .queue_level    (queue_level),
    .cfg_wen        (cfg_wen),
    .cfg_wdata      (cfg_wdata),
    .mismatch_total (mismatch_total),
    .outstanding    (outstanding)
  );

  // Receiver stalls
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Offer one item, with random idle cycles first; returns once accepted
  task automatic send_item(input logic act, input logic [NUM_KEYS-1:0] m);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    action     <= act;
    key_matrix <= m;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic scan(input logic [NUM_KEYS-1:0] m);
    send_item(ACT_SCAN, m);
  endtask

  task automatic read_key();
    send_item(ACT_READ, NUM_KEYS'($urandom_range(0, 65535)));
  endtask

  // Stop sending and wait until every result is back, then let the pipe settle
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_debounce(input logic [TICKS_W-1:0] ticks);
    drain_results();
    cfg_wen   <= 1'b1;
    cfg_wdata <= ticks;
    @(posedge clk);
    cfg_wen   <= 1'b0;
  endtask

  // Keypress-like sequences: press, hold, release, quiet ticks, with reads
  // mixed in at a rate that shifts so the queue both fills and empties
  task automatic run_random(input int n_items);
    int                  read_pct;
    int                  pick;
    int                  k;
    logic [NUM_KEYS-1:0] m;
    read_pct = 30;
    for (int i = 0; i < n_items; i++) begin
      if (i % 50 == 0) begin
        pick = $urandom_range(2);
        read_pct = (pick == 0) ? 10 : (pick == 1) ? 30 : 55;
      end
      if ($urandom_range(99) < read_pct) begin
        read_key();
      end else begin
        pick = $urandom_range(99);
        if (pick < 35) begin
          m = held_matrix;
        end else if (pick < 60) begin
          m = '0;
        end else if (pick < 85) begin
          k = $urandom_range(NUM_KEYS - 1);
          m = NUM_KEYS'(1) << k;
          // other keys further along the scan order held at the same time
          if ($urandom_range(99) < 30)
            m = m | (NUM_KEYS'($urandom_range(0, 65535)) & ~((NUM_KEYS'(2) << k) - 1'b1));
        end else begin
          m = NUM_KEYS'($urandom_range(0, 65535));
        end
        held_matrix = m;
        scan(m);
      end
    end
  endtask

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed run at the reset debounce setting
    read_key();                          // read from an empty queue
    scan(16'h0001);                      // press '1'
    scan(16'h0001);                      // held, nothing queued
    scan(16'h8000);                      // switch straight to 'd'
    scan(16'h0000);                      // release, window opens
    scan(16'h0020);                      // press inside the window, rejected
    scan(16'h0020);                      // still held, never queued
    scan(16'h0000);                      // release again
    scan(16'h0000);
    scan(16'h0000);
    scan(16'h1000);                      // third tick after release, 's' taken
    scan(16'hFFFF);                      // all down, first in scan order wins
    for (int i = 0; i < 13; i++) begin
      // alternate keys without release until the queue overflows
      scan((i % 2 == 0) ? 16'h0008 : 16'h4000);
    end
    read_key();
    drain_results();

    // Random run: shortest and longest debounce, then moderate values
    set_debounce(8'd0);
    run_random(300);
    set_debounce(8'd255);
    run_random(100);
    tx_idle_pct = 45;
    rx_idle_pct = 25;
    set_debounce(TICKS_W'($urandom_range(1, 12)));
    run_random(300);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_debounce(TICKS_W'($urandom_range(1, 6)));
    run_random(250);
    drain_results();

    if (mismatch_total == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/kps_pkg.sv
hdl/kps_encoder.sv
hdl/kps_debounce.sv
hdl/kps_fifo.sv
hdl/matrix_keypad_scanner_unit.sv
dv/kps_checker.sv
dv/testbench.sv
